### hw/rtl/dedup_task_ring_queue_assert.svh
// Assertion macros used by the task ring queue top level.
`ifndef DEDUP_TASK_RING_QUEUE_ASSERT_SVH
`define DEDUP_TASK_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("task ring queue assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("task ring queue assertion failed");

`endif

### hw/rtl/dtrq_pkg.sv
// Package with the types, codes and defaults of the task ring queue.
package dtrq_pkg;

	// Default sizes of the queue.
	localparam int DEPTH_DEF     = 16;
	localparam int CODE_BITS_DEF = 8;

	// Fixed widths of the transfer fields.
	localparam int TASK_W = 8;
	localparam int OCC_W  = 4;

	// Command codes of an input transfer.
	typedef enum logic {
		CMD_SCHEDULE = 1'b0,
		CMD_TAKE     = 1'b1
	} cmd_t;

	// Input transfer payload.
	typedef struct packed {
		cmd_t              command;
		logic [TASK_W-1:0] task_code;
	} req_item_t;

	// Result transfer payload.
	typedef struct packed {
		logic [TASK_W-1:0] task_out;
		logic              task_valid;
		logic              was_duplicate;
		logic              was_full;
		logic [OCC_W-1:0]  occupancy;
	} rsp_item_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN,
		S_TAKE
	} state_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

### hw/rtl/dtrq_if.sv
// Handshake interfaces for the request and result channels of the task ring queue.
interface dtrq_req_if import dtrq_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dtrq_rsp_if import dtrq_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/dtrq_cell.sv
// One storage cell of the queue ring: holds a code, loads or takes its neighbor's code.
module dtrq_cell import dtrq_pkg::*; #(
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic [CODE_BITS-1:0] nbr_code,
	input  logic [CODE_BITS-1:0] load_code,
	output logic [CODE_BITS-1:0] code_q
);

	// A load appends a new entry; a shift moves the ring one place toward cell 0.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			code_q <= load_code;
		end else if (ctrl.shift) begin
			code_q <= nbr_code;
		end
	end

endmodule

### hw/rtl/dedup_task_ring_queue.sv
// Top level of the duplicate-suppressing task ring queue.
// The queue keeps up to DEPTH-1 task codes in a ring of DEPTH cells, oldest entry in cell 0.
// A schedule transfer rotates the whole ring once past a single comparator at cell 0: the
// item is accepted, the ring rotates through all DEPTH cells, and a finish step writes the
// result; a take transfer pops cell 0 with one ring shift as it writes its result.
// One item is worked on at a time; the result sits in an output register, and the next item
// is accepted while it waits, though its own result waits for that register to free up.
// The occupancy field carries the low four bits of the entry count after the operation.
`include "dedup_task_ring_queue_assert.svh"

module dedup_task_ring_queue import dtrq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int CODE_BITS = CODE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dtrq_req_if.sink  req,
	dtrq_rsp_if.source rsp
);

	localparam int CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DEPTH - 1);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [CNT_W-1:0]     step_q, step_d;
	logic                 found_q, found_d;
	logic [CODE_BITS-1:0] item_code_q;
	cmd_t                 item_cmd_q;
	rsp_item_t            out_q, out_d;
	logic                 out_valid_q;
	logic                 out_load;
	logic                 out_free;
	logic                 shift_en;
	logic                 load_en;
	logic                 req_ready;
	logic [CODE_BITS-1:0] code_in;
	logic [CODE_BITS-1:0] cell_code [DEPTH];
	cell_ctrl_t           cell_ctrl [DEPTH];

	// Only the low CODE_BITS of the incoming code take part.
	assign code_in = CODE_BITS'(req.payload.task_code);

	// Ring of cells; each cell takes the code of the next one, the last wraps to cell 0.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		assign cell_ctrl[k].shift = shift_en;
		assign cell_ctrl[k].load  = load_en && (count_q == CNT_W'(k));

		dtrq_cell #(
			.CODE_BITS(CODE_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[k]),
			.nbr_code (cell_code[(k + 1) % DEPTH]),
			.load_code(item_code_q),
			.code_q   (cell_code[k])
		);
	end

	// The result register is free when empty or when its transfer completes now.
	assign out_free = !out_valid_q || rsp.ready;

	// Sequencer: next state, ring control and result assembly.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		step_d    = step_q;
		found_d   = found_q;
		shift_en  = 1'b0;
		load_en   = 1'b0;
		req_ready = 1'b0;
		out_load  = 1'b0;
		out_d     = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					step_d  = '0;
					found_d = 1'b0;
					state_d = (req.payload.command == CMD_TAKE) ? S_TAKE : S_SCAN;
				end
			end
			S_SCAN: begin
				// Cell 0 holds entry number step_q; only queued entries count.
				shift_en = 1'b1;
				if ((step_q < count_q) && (cell_code[0] == item_code_q)) begin
					found_d = 1'b1;
				end
				step_d = CNT_W'(step_q + 1'b1);
				if (step_q == STEP_LAST) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (found_q) begin
						out_d.was_duplicate = 1'b1;
					end else if (count_q == CNT_FULL) begin
						out_d.was_full = 1'b1;
					end else begin
						load_en = 1'b1;
						count_d = CNT_W'(count_q + 1'b1);
					end
					out_d.occupancy = OCC_W'(count_d);
				end
			end
			S_TAKE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (count_q != '0) begin
						out_d.task_out   = TASK_W'(cell_code[0]);
						out_d.task_valid = 1'b1;
						shift_en         = 1'b1;
						count_d          = CNT_W'(count_q - 1'b1);
					end
					out_d.occupancy = OCC_W'(count_d);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			found_q <= found_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Accepted item and result payload registers.
	always_ff @(posedge clk) begin
		if (req_ready && req.valid) begin
			item_cmd_q  <= req.payload.command;
			item_code_q <= code_in;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign req.ready   = req_ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// The entry count never exceeds DEPTH-1, one below the number of ring cells.
	`DTRQ_ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	// A result reports at most one outcome.
	`DTRQ_ASSERT_IMPL(a_one_outcome, clk, arst_n, out_valid_q,
		$onehot0({out_q.task_valid, out_q.was_duplicate, out_q.was_full}))
	// The count is steady while the ring rotates for a scan.
	`DTRQ_ASSERT_NEXT(a_scan_count, clk, arst_n, state_q == S_SCAN, $stable(count_q))
	// A loaded result carries the new entry count, and the right operation kind.
	`DTRQ_ASSERT_NEXT(a_occ_match, clk, arst_n, out_load,
		(out_q.occupancy == OCC_W'(count_q)) &&
		((item_cmd_q == CMD_TAKE) || !out_q.task_valid))

endmodule
